// ===== hdl/cse_pkg.sv =====
package cse_pkg;

    // Q format of values and of the curve parameter
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int U_W       = FRAC_BITS + 1;
    localparam int WGT_W     = FRAC_BITS + 3;

    // angle wrap: a full turn is TURN_STEPS * 2^LOW_W
    localparam int TURN_STEPS = 45;
    localparam int STEP_W     = 6;
    localparam int D_W        = VAL_W + 2;
    localparam int LOW_W      = FRAC_BITS + 3;
    localparam int HI_W       = D_W - LOW_W;
    localparam int Y_W        = HI_W + 1;
    localparam int MOD_K      = TURN_STEPS * ((2 ** (HI_W - 1) + TURN_STEPS - 1) / TURN_STEPS);
    localparam int RCP_SH     = Y_W + 6;
    localparam int RCP_M      = (2 ** RCP_SH + TURN_STEPS - 1) / TURN_STEPS;
    localparam int RCP_W      = Y_W + 1;
    localparam int Q_W        = Y_W - 5;
    localparam int T_W        = FRAC_BITS + 9;

    // datapath widths
    localparam int OP_W   = (T_W > VAL_W) ? T_W : VAL_W;
    localparam int PROD_W = OP_W + WGT_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RES_W  = ACC_W - FRAC_BITS;

    localparam int PIPE_DEPTH = 8;

    localparam logic [U_W-1:0]       ONE       = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] HALF_LSB  = {1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic [T_W-1:0]       HALF_TURN = T_W'(180) << FRAC_BITS;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

    localparam int MODE_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_BEZIER  = 2'd1,
        MODE_HERMITE = 2'd2,
        MODE_EULER   = 2'd3
    } t_interp_mode;

    localparam t_interp_mode MODE_RESET = MODE_BEZIER;

    typedef struct packed {
        logic signed [VAL_W-1:0] point_0;
        logic signed [VAL_W-1:0] point_1;
        logic signed [VAL_W-1:0] point_2;
        logic signed [VAL_W-1:0] point_3;
        logic [U_W-1:0]          param_u;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] curve_value;
        logic                    saturated;
    } t_result;

endpackage

// ===== hdl/curve_segment_evaluator.sv =====
// Curve segment evaluator: one coordinate of a linear, Bezier, Hermite or angle segment.
// Throughput: one transfer per cycle, every cycle; busy is high only while in reset.
// o_result_valid marks each result as it leaves the 8 register stages.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset (synchronous, active low) empties the pipeline and sets the mode to cubic Bezier.
module curve_segment_evaluator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cse_pkg::t_item                      i_item,
    output logic                                o_result_valid,
    output cse_pkg::t_result                    o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cse_pkg::MODE_W-1:0]          i_cfg_data
);
    import cse_pkg::*;

    // Stage map
    //   1: clamp u, v = 1 - u, angle difference d = p1 - p0 + 180 deg
    //   2: u^2, v^2 (rounded); high part of d offset positive, times reciprocal of 45
    //   3: u^3, Bezier weights; remainder of the turn count mod 45
    //   4: per-mode weight and operand select (Hermite basis, wrapped angle)
    //   5: four lane multipliers, operand x weight
    //   6: pairwise sums, rounding half added
    //   7: final sum
    //   8: floor shift by FRAC_BITS, saturate, result register
    // The model's exact 64-bit sum is kept in ACC_W bits, wide enough for every mode.

    function automatic logic [U_W-1:0] mul_rnd(input logic [U_W+1:0] a,
                                               input logic [U_W-1:0] b);
        logic [2*U_W+1:0] prod;
        prod = (2*U_W+2)'(a) * (2*U_W+2)'(b) + (2*U_W+2)'(HALF_LSB);
        return prod[FRAC_BITS +: U_W];
    endfunction

    logic accept;
    assign accept      = start && !busy;
    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;

    // ---------------------------------------------------------------- mode register
    t_interp_mode r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= t_interp_mode'(i_cfg_data);
        end
    end

    // ---------------------------------------------------------------- valid bits
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;

    assign n_vld = {r_vld[PIPE_DEPTH-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_result_valid = r_vld[PIPE_DEPTH-1];

    // ---------------------------------------------------------------- stage 1
    logic signed [VAL_W-1:0] r1_p [4];
    logic [U_W-1:0]          r1_u;
    logic [U_W-1:0]          r1_v;
    logic [D_W-1:0]          r1_d;
    logic [U_W-1:0]          n1_u;
    logic [U_W-1:0]          n1_v;
    logic [D_W-1:0]          n1_d;

    always_comb begin
        // u above one counts as one
        n1_u = (i_item.param_u > ONE) ? ONE : i_item.param_u;
        n1_v = ONE - n1_u;
        n1_d = D_W'($signed(i_item.point_1)) - D_W'($signed(i_item.point_0))
             + D_W'(HALF_TURN);
    end

    always_ff @(posedge i_clk) begin
        r1_p[0] <= i_item.point_0;
        r1_p[1] <= i_item.point_1;
        r1_p[2] <= i_item.point_2;
        r1_p[3] <= i_item.point_3;
        r1_u    <= n1_u;
        r1_v    <= n1_v;
        r1_d    <= n1_d;
    end

    // ---------------------------------------------------------------- stage 2
    // 360 deg = 45 * 2^LOW_W: the low LOW_W bits pass, the high part is taken mod 45.
    // MOD_K (a multiple of 45) makes the high part non-negative; the reciprocal is exact
    // over that range.
    logic signed [VAL_W-1:0] r2_p [4];
    logic [U_W-1:0]          r2_u;
    logic [U_W-1:0]          r2_v;
    logic [U_W-1:0]          r2_uu;
    logic [U_W-1:0]          r2_vv;
    logic [LOW_W-1:0]        r2_dlow;
    logic [Y_W-1:0]          r2_y;
    logic [Q_W-1:0]          r2_q;
    logic [U_W-1:0]          n2_uu;
    logic [U_W-1:0]          n2_vv;
    logic [Y_W-1:0]          n2_y;
    logic [Q_W-1:0]          n2_q;

    always_comb begin
        logic [Y_W+RCP_W-1:0] q_prod;
        n2_uu  = mul_rnd((U_W+2)'(r1_u), r1_u);
        n2_vv  = mul_rnd((U_W+2)'(r1_v), r1_v);
        n2_y   = Y_W'($signed(r1_d[D_W-1:LOW_W])) + Y_W'(MOD_K);
        q_prod = (Y_W+RCP_W)'(n2_y) * (Y_W+RCP_W)'(RCP_M);
        n2_q   = q_prod[RCP_SH +: Q_W];
    end

    always_ff @(posedge i_clk) begin
        r2_p    <= r1_p;
        r2_u    <= r1_u;
        r2_v    <= r1_v;
        r2_uu   <= n2_uu;
        r2_vv   <= n2_vv;
        r2_dlow <= r1_d[LOW_W-1:0];
        r2_y    <= n2_y;
        r2_q    <= n2_q;
    end

    // ---------------------------------------------------------------- stage 3
    logic signed [VAL_W-1:0] r3_p [4];
    logic [U_W-1:0]          r3_u;
    logic [U_W-1:0]          r3_v;
    logic [U_W-1:0]          r3_uu;
    logic [U_W-1:0]          r3_uuu;
    logic [U_W-1:0]          r3_bw [4];
    logic [LOW_W-1:0]        r3_dlow;
    logic [STEP_W-1:0]       r3_r;
    logic [U_W-1:0]          n3_uuu;
    logic [U_W-1:0]          n3_bw [4];
    logic [STEP_W-1:0]       n3_r;

    always_comb begin
        logic [U_W+1:0] u3;
        logic [U_W+1:0] uu3;
        logic [Y_W-1:0] rem;
        u3     = (U_W+2)'(r2_u) + (U_W+2)'({r2_u, 1'b0});
        uu3    = (U_W+2)'(r2_uu) + (U_W+2)'({r2_uu, 1'b0});
        n3_uuu = mul_rnd((U_W+2)'(r2_uu), r2_u);
        // Bernstein weights
        n3_bw[0] = mul_rnd((U_W+2)'(r2_vv), r2_v);
        n3_bw[1] = mul_rnd(u3, r2_vv);
        n3_bw[2] = mul_rnd(uu3, r2_v);
        n3_bw[3] = n3_uuu;
        rem      = r2_y - Y_W'(r2_q) * Y_W'(TURN_STEPS);
        n3_r     = rem[STEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r3_p    <= r2_p;
        r3_u    <= r2_u;
        r3_v    <= r2_v;
        r3_uu   <= r2_uu;
        r3_uuu  <= n3_uuu;
        r3_bw   <= n3_bw;
        r3_dlow <= r2_dlow;
        r3_r    <= n3_r;
    end

    // ---------------------------------------------------------------- stage 4
    logic signed [OP_W-1:0]  r4_op [4];
    logic signed [WGT_W-1:0] r4_w [4];
    logic signed [OP_W-1:0]  n4_op [4];
    logic signed [WGT_W-1:0] n4_w [4];

    always_comb begin
        logic signed [WGT_W-1:0] e_u;
        logic signed [WGT_W-1:0] e_v;
        logic signed [WGT_W-1:0] e_uu;
        logic signed [WGT_W-1:0] e_uuu;
        logic signed [WGT_W-1:0] e_one;
        logic signed [WGT_W-1:0] uu2;
        logic signed [WGT_W-1:0] uu3;
        logic signed [WGT_W-1:0] uuu2;
        logic [T_W-1:0]          t_raw;
        logic signed [T_W-1:0]   e_t;
        e_u   = WGT_W'(r3_u);
        e_v   = WGT_W'(r3_v);
        e_uu  = WGT_W'(r3_uu);
        e_uuu = WGT_W'(r3_uuu);
        e_one = WGT_W'(ONE);
        uu2   = e_uu <<< 1;
        uu3   = uu2 + e_uu;
        uuu2  = e_uuu <<< 1;
        // wrapped angle difference in [-180, 180) deg
        t_raw = {r3_r, r3_dlow};
        e_t   = t_raw - HALF_TURN;

        for (int i = 0; i < 4; i++) begin
            n4_op[i] = OP_W'(r3_p[i]);
            n4_w[i]  = '0;
        end
        case (r_mode)
            MODE_LINEAR: begin
                n4_w[0] = e_v;
                n4_w[1] = e_u;
            end
            MODE_BEZIER: begin
                for (int i = 0; i < 4; i++) begin
                    n4_w[i] = WGT_W'(r3_bw[i]);
                end
            end
            MODE_HERMITE: begin
                n4_w[0] = uuu2 - uu3 + e_one;
                n4_w[1] = uu3 - uuu2;
                n4_w[2] = e_uuu - uu2 + e_u;
                n4_w[3] = e_uuu - e_uu;
            end
            MODE_EULER: begin
                n4_w[0]  = e_one;
                n4_w[1]  = e_u;
                n4_op[1] = OP_W'(e_t);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r4_op <= n4_op;
        r4_w  <= n4_w;
    end

    // ---------------------------------------------------------------- stage 5
    logic signed [PROD_W-1:0] r5_prod [4];
    logic signed [PROD_W-1:0] n5_prod [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n5_prod[i] = PROD_W'(r4_op[i]) * PROD_W'(r4_w[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r5_prod <= n5_prod;
    end

    // ---------------------------------------------------------------- stage 6
    logic signed [ACC_W-1:0] r6_s01;
    logic signed [ACC_W-1:0] r6_s23;
    logic signed [ACC_W-1:0] n6_s01;
    logic signed [ACC_W-1:0] n6_s23;

    always_comb begin
        n6_s01 = ACC_W'(r5_prod[0]) + ACC_W'(r5_prod[1])
               + $signed(ACC_W'(HALF_LSB));
        n6_s23 = ACC_W'(r5_prod[2]) + ACC_W'(r5_prod[3]);
    end

    always_ff @(posedge i_clk) begin
        r6_s01 <= n6_s01;
        r6_s23 <= n6_s23;
    end

    // ---------------------------------------------------------------- stage 7
    logic signed [ACC_W-1:0] r7_acc;
    logic signed [ACC_W-1:0] n7_acc;

    assign n7_acc = r6_s01 + r6_s23;

    always_ff @(posedge i_clk) begin
        r7_acc <= n7_acc;
    end

    // ---------------------------------------------------------------- stage 8
    // dropping the low FRAC_BITS of a two's complement sum is a floor
    t_result r_out;
    t_result n_out;

    always_comb begin
        logic [RES_W-1:0]       res;
        logic [RES_W-VAL_W:0]   top;
        res = r7_acc[ACC_W-1:FRAC_BITS];
        top = res[RES_W-1:VAL_W-1];
        if (top == '0 || top == '1) begin
            n_out.curve_value = res[VAL_W-1:0];
            n_out.saturated   = 1'b0;
        end else begin
            n_out.curve_value = res[RES_W-1] ? VAL_MIN : VAL_MAX;
            n_out.saturated   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result = r_out;

endmodule

// ===== hdl/cse_checker.sv =====
module cse_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_result_valid,
    input cse_pkg::t_result o_result
);
    import cse_pkg::*;

    localparam int LAT = PIPE_DEPTH;

    logic accept;
    assign accept = start && !busy;

    // every transfer in gives a result strobe once it has passed the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_result_valid)
        else $error("result strobe missing after transfer");

    // no result without a matching earlier transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept, LAT))
        else $error("result strobe without matching transfer");

    // a clamped result sits on one of the range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.saturated) |->
            (o_result.curve_value == VAL_MAX || o_result.curve_value == VAL_MIN))
        else $error("saturated result not at a range limit");

endmodule

bind curve_segment_evaluator cse_checker u_cse_checker (.*);

// ===== test/curve_segment_evaluator_tb.sv =====
module curve_segment_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cse_pkg::*;

    // fixed-point constants of the expected-value model, all in 64-bit signed
    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam longint HALF_L = ONE_L >> 1;
    localparam longint HALF_T = longint'(180) << FRAC_BITS;  // 180 degrees
    localparam longint FULL_T = HALF_T * 2;                   // 360 degrees
    localparam longint SAT_HI = (longint'(1) << (VAL_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    localparam int DEG         = 1 << FRAC_BITS;  // one degree in Q16.16
    localparam int IDLE_LIMIT  = 2000;            // cycles with no transfer at all
    localparam int MAX_REPORTS = 10;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_item            i_item;
    logic             o_result_valid;
    t_result          o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [MODE_W-1:0] i_cfg_data;

    // expected curve values, oldest first, one per accepted item
    t_result      expected_results[$];
    t_interp_mode shadow_mode;
    int           mismatches = 0;
    int           idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    curve_segment_evaluator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Expected value of one item.
    // Weights are built from rounded squares and cubes of u and v = 1 - u,
    // the weighted sum stays exact with FRAC_BITS extra fraction bits, and only the
    // final sum is rounded half up and clamped to 32 bits.
    // ------------------------------------------------------------------
    function automatic longint scale_round(input longint a, input longint b);
        // both operands are non-negative here
        return (a * b + HALF_L) >>> FRAC_BITS;
    endfunction

    function automatic t_result eval_curve(input t_interp_mode mode, input t_item it);
        longint  p0, p1, p2, p3;
        longint  u, v, uu, vv, uuu;
        longint  h00, h01, h10, h11;
        longint  acc, res, dang;
        t_result r;
        p0 = longint'($signed(it.point_0));
        p1 = longint'($signed(it.point_1));
        p2 = longint'($signed(it.point_2));
        p3 = longint'($signed(it.point_3));
        u  = it.param_u;
        if (u > ONE_L) begin
            u = ONE_L;  // parameter past the end clamps to the end point
        end
        v  = ONE_L - u;
        uu = scale_round(u, u);
        vv = scale_round(v, v);
        case (mode)
            MODE_LINEAR: begin
                acc = p0 * v + p1 * u;
            end
            MODE_BEZIER: begin
                acc = p0 * scale_round(vv, v) + p1 * scale_round(3 * u, vv)
                    + p2 * scale_round(3 * uu, v) + p3 * scale_round(uu, u);
            end
            MODE_HERMITE: begin
                uuu = scale_round(uu, u);
                h00 = 2 * uuu - 3 * uu + ONE_L;
                h01 = 3 * uu - 2 * uuu;
                h10 = uuu - 2 * uu + u;
                h11 = uuu - uu;
                acc = p0 * h00 + p1 * h01 + p2 * h10 + p3 * h11;
            end
            default: begin
                // shortest way round: wrap the exact difference into [-180,180)
                dang = (p1 - p0 + HALF_T) % FULL_T;
                if (dang < 0) begin
                    dang = dang + FULL_T;
                end
                dang = dang - HALF_T;
                acc  = p0 * ONE_L + dang * u;
            end
        endcase
        res = (acc + HALF_L) >>> FRAC_BITS;  // arithmetic shift gives the floor
        r.saturated = 1'b0;
        if (res > SAT_HI) begin
            res = SAT_HI;
            r.saturated = 1'b1;
        end else if (res < SAT_LO) begin
            res = SAT_LO;
            r.saturated = 1'b1;
        end
        r.curve_value = res[VAL_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the DUT's
    // registers update, so it sees the values that the edge transfers.
    // Results are checked first, then the item taken at this edge is
    // predicted with the mode in force, then a mode write is applied.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        bit      moved;
        if (!i_rst_n) begin
            shadow_mode = MODE_RESET;
            expected_results.delete();
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (o_result_valid) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: value %0d sat %0b",
                                 $signed(o_result.curve_value), o_result.saturated);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.curve_value !== want.curve_value ||
                        o_result.saturated !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch: expected value %0d sat %0b, got value %0d sat %0b",
                                     $signed(want.curve_value), want.saturated,
                                     $signed(o_result.curve_value), o_result.saturated);
                        end
                    end
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                expected_results.insert(expected_results.size(),
                                        eval_curve(shadow_mode, i_item));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                shadow_mode = t_interp_mode'(i_cfg_data);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("curve_segment_evaluator test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver side: inputs change only at falling edges.
    // ------------------------------------------------------------------

    // one item: optional gap with start low, then hold start until the transfer
    task automatic send_item(input t_item it, input int gap_max);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // stop sending and wait until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    // mode writes happen only with the pipeline empty
    task automatic set_mode(input logic [MODE_W-1:0] mode);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_item mk_item(input int a, input int b, input int c, input int d,
                                      input int unsigned u);
        t_item it;
        it.point_0 = a;
        it.point_1 = b;
        it.point_2 = c;
        it.point_3 = d;
        it.param_u = u[U_W-1:0];
        return it;
    endfunction

    // points: rails, small values, angles near the wrap, and full-range noise
    function automatic int rand_point();
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return int'($urandom_range(0, 2097152)) - 1048576;
            3:       return int'($urandom_range(0, 720 * DEG)) - 360 * DEG;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned rand_param();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return ONE;
            2:       return $urandom_range(ONE + 1, 2 * ONE - 1);  // past the end
            default: return $urandom_range(0, ONE);
        endcase
    endfunction

    function automatic t_item rand_item();
        return mk_item(rand_point(), rand_point(), rand_point(), rand_point(), rand_param());
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // no mode write yet: the block must come out of reset in Bezier mode
    task automatic test_reset_mode();
        send_item(mk_item(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, 0), 19);
        send_item(mk_item(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 21845), 0);
        send_item(mk_item(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, 43691), 0);
        send_item(mk_item(0, 0, 0, 0, ONE), 5);
        send_item(mk_item(1, -1, VAL_MAX, VAL_MIN, 2 * ONE - 1), 0);
    endtask

    task automatic test_linear_ends();
        set_mode(MODE_LINEAR);
        send_item(mk_item(VAL_MAX, VAL_MIN, 7, 7, 0), 0);
        send_item(mk_item(VAL_MAX, VAL_MIN, 7, 7, ONE), 0);
        send_item(mk_item(VAL_MIN, VAL_MAX, 0, 0, ONE / 2), 3);
        send_item(mk_item(-1, 1, VAL_MAX, VAL_MIN, ONE + 1), 0);
    endtask

    // slopes large enough to push the curve past both rails
    task automatic test_hermite_overshoot();
        set_mode(MODE_HERMITE);
        send_item(mk_item(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, ONE / 2), 0);
        send_item(mk_item(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, ONE / 2), 0);
        send_item(mk_item(VAL_MAX, VAL_MIN, 0, 0, 0), 11);
        send_item(mk_item(VAL_MAX, VAL_MIN, 0, 0, ONE), 0);
        send_item(mk_item(123, 456, VAL_MAX, VAL_MAX, 2 * ONE - 1), 0);
    endtask

    // angle wrap: exactly half a turn both ways, multiple turns, rail overflow
    task automatic test_euler_wrap();
        set_mode(MODE_EULER);
        send_item(mk_item(0, 180 * DEG, 0, 0, ONE), 0);
        send_item(mk_item(0, -180 * DEG, 0, 0, ONE), 0);
        send_item(mk_item(10 * DEG, -170 * DEG + 1, 0, 0, ONE / 2), 2);
        send_item(mk_item(VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, ONE), 0);
        send_item(mk_item(VAL_MAX, VAL_MAX - 190 * DEG, 0, 0, ONE), 0);
        send_item(mk_item(VAL_MIN, VAL_MIN + 190 * DEG, 0, 0, ONE), 0);
        send_item(mk_item(360 * DEG, -360 * DEG, -1, -1, ONE / 2), 0);
    endtask

    // random items in one mode; alternating stretches with and without gaps,
    // and one full pause halfway through
    task automatic test_random_mode(input logic [MODE_W-1:0] mode, input int count);
        set_mode(mode);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                drain_results();
            end
            send_item(rand_item(), ((i / 30) % 2 == 1) ? 0 : 19);
        end
    endtask

    // mode changes between short bursts, mode drawn at random each phase
    task automatic test_mode_hopping();
        for (int phase = 0; phase < 6; phase++) begin
            set_mode(MODE_W'($urandom_range(0, 3)));
            for (int i = 0; i < 25; i++) begin
                send_item(rand_item(), (phase % 2 == 0) ? 19 : 0);
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_mode();
        test_linear_ends();
        test_hermite_overshoot();
        test_euler_wrap();
        test_random_mode(MODE_BEZIER, 120);
        test_random_mode(MODE_LINEAR, 100);
        test_random_mode(MODE_HERMITE, 120);
        test_random_mode(MODE_EULER, 120);
        test_mode_hopping();

        // let the pipeline empty, then keep watching for stray strobes
        drain_results();
        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("curve_segment_evaluator test passed");
        end else begin
            $display("curve_segment_evaluator test failed");
        end
        $finish;
    end

endmodule
